// ----- rtl/core/rpe_pkg.sv -----
// shared types and constants for the rotary position embedding block
// no dependencies; imported by every module under rtl/core
package rpe_pkg;

  // request codes on in_req_type
  localparam logic REQ_TABLE = 1'b0;
  localparam logic REQ_DATA  = 1'b1;

  // configuration register indexes
  localparam logic REG_HEAD_DIM    = 1'b0;
  localparam logic REG_INTERLEAVED = 1'b1;

  // first-half buffer: fixed depth, also the upper limit on half a head
  localparam int BUF_DEPTH  = 64;
  localparam int BUF_AW     = 6;
  localparam int HALF_LIMIT = 64;

  typedef logic [BUF_AW-1:0] buf_addr_t;
  typedef logic [6:0]        elem_idx_t;

  // one angle table entry, cos in the low half and sin in the high half
  typedef struct packed {
    logic signed [15:0] sin_v;
    logic signed [15:0] cos_v;
  } angle_t;

  // per-pair information that travels alongside the operands
  typedef struct packed {
    elem_idx_t idx0;
    elem_idx_t idx1;
    logic      err;
    logic      last;
  } meta_t;

endpackage

// ----- rtl/core/rotary_position_embedding.sv -----
// rotary position embedding: element sequencer, angle table, pair buffer
// and rotation datapath; depends on rpe_pkg, rpe_angle_mem, rpe_half_buf, rpe_rotate
//
// Input channel (in_*): one word per handshake. A table word (req_type 0)
// writes one cos/sin entry at position*MAX_HALF_DIM+pair and gives no result.
// A data word (req_type 1) carries the next element of the current head.
// The first element of each pair goes into the pair buffer; the word that
// completes a pair gives two result words on out_*, the first element's
// result then the second's, with head_end on the last word of the head.
// Each completing word loads the first stage with its buffer and table
// reads; the pair then passes the product stage and the output register,
// which gives the second word once the first is taken. Throughput: one
// input word per cycle, bounded by the output at one word per cycle; in
// split mode the output paces a head's second half, two words per element.
// When out_ready is low the pipeline fills (three pairs in flight) before
// in_ready drops. Synchronous reset clears the element count and config
// (head_dim 128, split mode); the angle table and pair buffer are not
// cleared and must be written before use. A config write restarts the head.
module rotary_position_embedding #(
  parameter int MAX_POSITIONS = 1024,
  parameter int MAX_HALF_DIM  = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic [9:0]         in_table_position,
  input  logic [5:0]         in_table_pair,
  input  logic signed [15:0] in_table_cos,
  input  logic signed [15:0] in_table_sin,
  input  logic [11:0]        in_position,
  input  logic signed [15:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [6:0]         out_index,
  output logic signed [15:0] out_value,
  output logic               out_head_end,
  output logic               out_position_error
);
  import rpe_pkg::*;

  localparam int AW = $clog2(MAX_POSITIONS * MAX_HALF_DIM);
  localparam logic [6:0] HALF_CAP =
    7'((MAX_HALF_DIM < HALF_LIMIT) ? MAX_HALF_DIM : HALF_LIMIT);

  // config and element count
  logic [6:0] half_r;
  logic       mode_r;
  elem_idx_t  count_r;
  logic [6:0] half_nxt;
  elem_idx_t  count_nxt;
  logic [7:0] dim;

  // element sequencing
  logic       in_fire, is_data, complete, last;
  elem_idx_t  e;
  logic [5:0] pair;
  buf_addr_t  hb_waddr;
  meta_t      meta_nxt;

  // table access
  logic           tw_en;
  logic [AW-1:0]  tw_addr, tr_addr;
  angle_t         tw_data, ent;

  // first pipeline stage, aligned with the memory read data
  logic               s1_vld_r;
  meta_t              s1_meta_r;
  logic signed [15:0] s1_a1_r;
  logic               s1_ready;
  logic signed [15:0] a0;
  logic               out_second;

  assign dim     = {half_r, 1'b0};
  assign in_fire = in_valid && in_ready;
  assign is_data = in_req_type == REQ_DATA;
  assign in_ready = !s1_vld_r || s1_ready;

  always_comb begin
    half_nxt = cfg_wdata[7:1];
    if (half_nxt == 7'd0) begin
      half_nxt = 7'd1;
    end else if (half_nxt > HALF_CAP) begin
      half_nxt = HALF_CAP;
    end
  end

  always_comb begin
    e = ({1'b0, count_r} >= dim) ? '0 : count_r;
    if (mode_r) begin
      complete = e[0];
      pair     = e[6:1];
      hb_waddr = e[6:1];
      meta_nxt.idx0 = 7'(e - 7'd1);
    end else begin
      complete = e >= half_r;
      pair     = 6'(e - half_r);
      hb_waddr = e[5:0];
      meta_nxt.idx0 = 7'(pair);
    end
    last          = complete && ({1'b0, e} + 8'd1 == dim);
    meta_nxt.idx1 = e;
    meta_nxt.err  = 32'(in_position) >= 32'(MAX_POSITIONS);
    meta_nxt.last = last;
    count_nxt     = last ? '0 : 7'(e + 7'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r  <= HALF_CAP;
      mode_r  <= 1'b0;
      count_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_HEAD_DIM: begin
          half_r  <= half_nxt;
          count_r <= '0;
        end
        REG_INTERLEAVED: begin
          mode_r  <= cfg_wdata[0];
          count_r <= '0;
        end
        default: begin
          count_r <= count_r;
        end
      endcase
    end else if (in_fire && is_data) begin
      count_r <= count_nxt;
    end
  end

  // out-of-range table writes are dropped
  assign tw_en = in_fire && !is_data
              && (32'(in_table_position) < 32'(MAX_POSITIONS))
              && (32'(in_table_pair) < 32'(MAX_HALF_DIM));
  assign tw_addr = AW'(32'(in_table_position) * 32'(MAX_HALF_DIM) + 32'(in_table_pair));
  assign tr_addr = AW'(32'(in_position) * 32'(MAX_HALF_DIM) + 32'(pair));
  assign tw_data = '{sin_v: in_table_sin, cos_v: in_table_cos};

  rpe_angle_mem #(
    .AW(AW)
  ) u_angle_mem (
    .clk  (clk),
    .we   (tw_en),
    .waddr(tw_addr),
    .wdata(tw_data),
    .re   (in_fire && is_data && complete),
    .raddr(tr_addr),
    .rdata(ent)
  );

  // each data word either writes or reads the buffer, and a pair's read always
  // comes in a later cycle than its write, so no forwarding is needed
  rpe_half_buf u_half_buf (
    .clk  (clk),
    .we   (in_fire && is_data && !complete),
    .waddr(hb_waddr),
    .wdata(in_value),
    .re   (in_fire && is_data && complete),
    .raddr(pair),
    .rdata(a0)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_fire && is_data && complete;
    end
    if (in_fire && is_data && complete) begin
      s1_meta_r <= meta_nxt;
      s1_a1_r   <= in_value;
    end
  end

  rpe_rotate u_rotate (
    .clk               (clk),
    .rst_n             (rst_n),
    .s1_vld            (s1_vld_r),
    .s1_ready          (s1_ready),
    .a0                (a0),
    .a1                (s1_a1_r),
    .ent               (ent),
    .meta              (s1_meta_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_index         (out_index),
    .out_value         (out_value),
    .out_head_end      (out_head_end),
    .out_position_error(out_position_error),
    .out_second        (out_second)
  );

  a_count_in_head: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, count_r} < dim)
    else $error("element count outside the head");

  a_pair_second_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_second |=> out_valid && out_second)
    else $error("second word of a pair not presented");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !in_ready |=> s1_vld_r && $stable(s1_meta_r) && $stable(ent))
    else $error("stalled pair lost its operands");

endmodule

// ----- rtl/core/rpe_angle_mem.sv -----
// cos/sin angle table: one write and one read per cycle, registered read data
// depends on rpe_pkg
module rpe_angle_mem #(
  parameter int AW = 16
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  rpe_pkg::angle_t wdata,
  input  logic           re,
  input  logic [AW-1:0]  raddr,
  output rpe_pkg::angle_t rdata
);
  import rpe_pkg::*;

  localparam int DEPTH = 1 << AW;

  angle_t mem [DEPTH];
  angle_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low, so a stalled pair keeps its entry
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/rpe_half_buf.sv -----
// buffer for the first element of each pair, registered read data
// depends on rpe_pkg
module rpe_half_buf (
  input  logic               clk,
  input  logic               we,
  input  rpe_pkg::buf_addr_t waddr,
  input  logic signed [15:0] wdata,
  input  logic               re,
  input  rpe_pkg::buf_addr_t raddr,
  output logic signed [15:0] rdata
);
  import rpe_pkg::*;

  logic signed [15:0] mem [BUF_DEPTH];
  logic signed [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/rpe_rotate.sv -----
// rotation datapath: product stage, combinational round/saturate, and the output
// register that hands out the two words of a pair; depends on rpe_pkg
module rpe_rotate (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s1_vld,
  output logic               s1_ready,
  input  logic signed [15:0] a0,
  input  logic signed [15:0] a1,
  input  rpe_pkg::angle_t    ent,
  input  rpe_pkg::meta_t     meta,
  output logic               out_valid,
  input  logic               out_ready,
  output rpe_pkg::elem_idx_t out_index,
  output logic signed [15:0] out_value,
  output logic               out_head_end,
  output logic               out_position_error,
  output logic               out_second
);
  import rpe_pkg::*;

  function automatic logic signed [15:0] round_sat(input logic signed [33:0] x);
    logic signed [33:0] t;
    logic signed [19:0] q;
    t = x + 34'sd8192;
    q = 20'(t >>> 14);
    if (q > 20'sd32767) begin
      round_sat = 16'sh7fff;
    end else if (q < -20'sd32768) begin
      round_sat = 16'sh8000;
    end else begin
      round_sat = 16'(q);
    end
  endfunction

  // product stage
  logic               s2_vld_r;
  meta_t              s2_meta_r;
  logic signed [15:0] s2_a0_r, s2_a1_r;
  logic signed [31:0] p_a0c_r, p_a1s_r, p_a1c_r, p_a0s_r;
  logic               s2_ready;

  // output stage
  logic               s3_vld_r;
  logic               s3_phase_r;
  meta_t              s3_meta_r;
  logic signed [15:0] s3_r0_r, s3_r1_r;
  logic               s3_free;

  logic signed [33:0] sum0, sum1;
  logic signed [15:0] r0_nxt, r1_nxt;

  assign s3_free  = !s3_vld_r || (out_ready && s3_phase_r);
  assign s2_ready = !s2_vld_r || s3_free;
  assign s1_ready = s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_ready) begin
      s2_vld_r <= s1_vld;
    end
    if (s2_ready) begin
      s2_meta_r <= meta;
      s2_a0_r   <= a0;
      s2_a1_r   <= a1;
      p_a0c_r   <= a0 * ent.cos_v;
      p_a1s_r   <= a1 * ent.sin_v;
      p_a1c_r   <= a1 * ent.cos_v;
      p_a0s_r   <= a0 * ent.sin_v;
    end
  end

  always_comb begin
    sum0 = 34'(p_a0c_r) - 34'(p_a1s_r);
    sum1 = 34'(p_a1c_r) + 34'(p_a0s_r);
    if (s2_meta_r.err) begin
      // position beyond the table: pass the pair through unrotated
      r0_nxt = s2_a0_r;
      r1_nxt = s2_a1_r;
    end else begin
      r0_nxt = round_sat(sum0);
      r1_nxt = round_sat(sum1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r   <= 1'b0;
      s3_phase_r <= 1'b0;
    end else if (s3_free) begin
      s3_vld_r   <= s2_vld_r;
      s3_phase_r <= 1'b0;
    end else if (out_ready) begin
      s3_phase_r <= 1'b1;
    end
    if (s3_free) begin
      s3_meta_r <= s2_meta_r;
      s3_r0_r   <= r0_nxt;
      s3_r1_r   <= r1_nxt;
    end
  end

  assign out_valid          = s3_vld_r;
  assign out_index          = s3_phase_r ? s3_meta_r.idx1 : s3_meta_r.idx0;
  assign out_value          = s3_phase_r ? s3_r1_r : s3_r0_r;
  assign out_head_end       = s3_phase_r && s3_meta_r.last;
  assign out_position_error = s3_meta_r.err;
  assign out_second         = s3_phase_r;

endmodule

// ----- tb/rope_checker.sv -----
// rotary position embedding checker: mirrors the angle table, pair buffer and
// element count, predicts every result word and compares it; uses rpe_pkg
module rope_checker #(
  parameter int MAX_POSITIONS = 1024,
  parameter int MAX_HALF_DIM  = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_req_type,
  input  logic [9:0]         in_table_position,
  input  logic [5:0]         in_table_pair,
  input  logic signed [15:0] in_table_cos,
  input  logic signed [15:0] in_table_sin,
  input  logic [11:0]        in_position,
  input  logic signed [15:0] in_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [6:0]         out_index,
  input  logic signed [15:0] out_value,
  input  logic               out_head_end,
  input  logic               out_position_error,
  output int                 fail_count,
  output int                 words_due
);
  import rpe_pkg::*;

  typedef struct {
    logic [6:0]         idx;
    logic signed [15:0] val;
    logic               head_end;
    logic               err;
  } rope_word_t;

  angle_t             angle_store [MAX_POSITIONS*MAX_HALF_DIM];
  logic signed [15:0] first_half [BUF_DEPTH];
  int unsigned        elem_count;
  logic [7:0]         head_dim;
  logic               interleaved;
  rope_word_t         rotated_words [$];
  int                 words_seen;

  // round half up at 2^-14, then clamp to 16 bits
  function automatic logic signed [15:0] round_q14(longint acc);
    longint q;
    q = (acc + 64'sd8192) >>> 14;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic int unsigned half_len(logic [7:0] dim);
    int unsigned h;
    h = dim >> 1;
    if (h < 1) h = 1;
    if (h > HALF_LIMIT) h = HALF_LIMIT;
    if (h > MAX_HALF_DIM) h = MAX_HALF_DIM;
    return h;
  endfunction

  task automatic report(string msg);
    $display("[%0t] rope check: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_word();
    rope_word_t want;
    if (rotated_words.size() == 0) begin
      report($sformatf("unexpected word, index %0d value %0d", out_index, out_value));
      return;
    end
    want = rotated_words.pop_front();
    if (out_index !== want.idx)
      report($sformatf("word %0d index: got %0d, want %0d", words_seen, out_index, want.idx));
    if (out_value !== want.val)
      report($sformatf("word %0d value: got %0d, want %0d", words_seen, out_value, want.val));
    if (out_head_end !== want.head_end)
      report($sformatf("word %0d head_end: got %b, want %b", words_seen, out_head_end,
                       want.head_end));
    if (out_position_error !== want.err)
      report($sformatf("word %0d position_error: got %b, want %b", words_seen,
                       out_position_error, want.err));
    words_seen++;
  endtask

  task automatic predict_element();
    int unsigned        h, dim, e, pair, i0, i1;
    logic signed [15:0] a0, a1, r0, r1;
    longint             c, s;
    angle_t             ent;
    logic               err, last;
    h   = half_len(head_dim);
    dim = 2 * h;
    e   = elem_count;
    if (e >= dim) e = 0;
    if (interleaved) begin
      pair = e >> 1;
      if (e % 2 == 0) begin
        first_half[pair % BUF_DEPTH] = in_value;
        elem_count = e + 1;
        return;
      end
      i0 = e - 1;
      i1 = e;
    end else begin
      if (e < h) begin
        first_half[e % BUF_DEPTH] = in_value;
        elem_count = e + 1;
        return;
      end
      pair = e - h;
      i0 = pair;
      i1 = e;
    end
    a0  = first_half[pair % BUF_DEPTH];
    a1  = in_value;
    err = (in_position >= MAX_POSITIONS);
    if (err) begin
      // out of table: pair passes through unrotated
      r0 = a0;
      r1 = a1;
    end else begin
      ent = angle_store[in_position*MAX_HALF_DIM + pair];
      c   = ent.cos_v;
      s   = ent.sin_v;
      r0  = round_q14(a0 * c - a1 * s);
      r1  = round_q14(a1 * c + a0 * s);
    end
    last = (e + 1 == dim);
    elem_count = last ? 0 : e + 1;
    rotated_words.push_back('{7'(i0), r0, 1'b0, err});
    rotated_words.push_back('{7'(i1), r1, last, err});
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      elem_count  = 0;
      head_dim    = 8'd128;
      interleaved = 1'b0;
      rotated_words.delete();
    end else begin
      if (out_valid && out_ready) check_word();
      if (cfg_wr_en) begin
        if (cfg_index == REG_HEAD_DIM) head_dim = cfg_wdata;
        else interleaved = cfg_wdata[0];
        elem_count = 0;
      end
      if (in_valid && in_ready) begin
        if (in_req_type == REQ_TABLE) begin
          if (in_table_position < MAX_POSITIONS && in_table_pair < MAX_HALF_DIM)
            angle_store[in_table_position*MAX_HALF_DIM + in_table_pair] =
              '{sin_v: in_table_sin, cos_v: in_table_cos};
        end else begin
          predict_element();
        end
      end
    end
    words_due <= rotated_words.size();
  end

endmodule

// ----- tb/rotary_position_embedding_tb.sv -----
// testbench top for rotary_position_embedding: clock, reset, word stimulus
// with bursty sender and stalling receiver; depends on that module, rpe_pkg, rope_checker
module rotary_position_embedding_tb;
  import rpe_pkg::*;

  localparam int MAX_POSITIONS = 1024;
  localparam int MAX_HALF_DIM  = 64;
  localparam int WORD_TARGET   = 1850;
  localparam int SETTLE        = 8;
  localparam int CYCLE_LIMIT   = 500000;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_wr_en;
  logic               cfg_index;
  logic [7:0]         cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic               in_req_type;
  logic [9:0]         in_table_position;
  logic [5:0]         in_table_pair;
  logic signed [15:0] in_table_cos;
  logic signed [15:0] in_table_sin;
  logic [11:0]        in_position;
  logic signed [15:0] in_value;
  logic               out_valid;
  logic               out_ready;
  logic [6:0]         out_index;
  logic signed [15:0] out_value;
  logic               out_head_end;
  logic               out_position_error;
  int                 fail_count;
  int                 words_due;

  // stimulus-side view of the element sequencer
  int unsigned gen_half;
  int unsigned gen_count;
  logic        gen_mode;
  bit          angle_loaded [MAX_POSITIONS*MAX_HALF_DIM];
  logic [9:0]  hot_positions [8];
  int          burst_left;
  int          sent_words;
  int          cycles;
  rx_mode_t    rx_mode;
  int          rx_left;
  int          rx_beat;
  logic [7:0]  dim_choices [13] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd6, 8'd8, 8'd16,
                                    8'd32, 8'd64, 8'd127, 8'd128, 8'd255};

  always #4 clk = ~clk;

  rotary_position_embedding #(
    .MAX_POSITIONS(MAX_POSITIONS),
    .MAX_HALF_DIM (MAX_HALF_DIM)
  ) u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_table_position(in_table_position), .in_table_pair(in_table_pair),
    .in_table_cos(in_table_cos), .in_table_sin(in_table_sin),
    .in_position(in_position), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_index(out_index),
    .out_value(out_value), .out_head_end(out_head_end),
    .out_position_error(out_position_error)
  );

  rope_checker #(
    .MAX_POSITIONS(MAX_POSITIONS),
    .MAX_HALF_DIM (MAX_HALF_DIM)
  ) u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_table_position(in_table_position), .in_table_pair(in_table_pair),
    .in_table_cos(in_table_cos), .in_table_sin(in_table_sin),
    .in_position(in_position), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_index(out_index),
    .out_value(out_value), .out_head_end(out_head_end),
    .out_position_error(out_position_error),
    .fail_count(fail_count), .words_due(words_due)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: each stretch picks a stall pattern, open stretches included
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(32, 256);
    end
    rx_left--;
    rx_beat++;
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= rx_beat[2];
    endcase
  end

  function automatic int unsigned half_span(logic [7:0] dim);
    int unsigned h;
    h = dim >> 1;
    if (h < 1) h = 1;
    if (h > HALF_LIMIT) h = HALF_LIMIT;
    if (h > MAX_HALF_DIM) h = MAX_HALF_DIM;
    return h;
  endfunction

  function automatic bit pair_completes();
    int unsigned e;
    e = (gen_count >= 2 * gen_half) ? 0 : gen_count;
    return gen_mode ? e[0] : (e >= gen_half);
  endfunction

  function automatic logic [11:0] choose_position(bit completes);
    int r;
    r = $urandom_range(0, 99);
    if (!completes) return 12'($urandom_range(0, 4095));
    if (r < 12) return 12'($urandom_range(MAX_POSITIONS, 4095));
    if (r < 60) return {2'b00, hot_positions[$urandom_range(0, 7)]};
    return 12'($urandom_range(0, MAX_POSITIONS - 1));
  endfunction

  function automatic logic signed [15:0] random_value();
    int r;
    r = $urandom_range(0, 99);
    case (r % 5)
      0:       if (r < 10) return 16'sh8000;
      1:       if (r < 10) return 16'sh7fff;
      2:       if (r < 10) return -16'sd1;
      default: ;
    endcase
    return 16'($urandom);
  endfunction

  function automatic logic signed [15:0] random_angle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 16'sd16384;
    if (r < 8) return -16'sd16384;
    if (r < 11) return 16'sd0;
    if (r < 14) return 16'sd8192;
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  // offer one word and hold it until taken; bursts end in a random gap, maybe none
  task automatic send_word(input logic req, input logic [9:0] tpos, input logic [5:0] tpair,
                           input logic signed [15:0] tcos, input logic signed [15:0] tsin,
                           input logic [11:0] pos, input logic signed [15:0] val);
    int gap;
    in_valid          <= 1'b1;
    in_req_type       <= req;
    in_table_position <= tpos;
    in_table_pair     <= tpair;
    in_table_cos      <= tcos;
    in_table_sin      <= tsin;
    in_position       <= pos;
    in_value          <= val;
    do @(posedge clk); while (!in_ready);
    sent_words++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_angle(input logic [9:0] pos, input logic [5:0] pair,
                            input logic signed [15:0] c, input logic signed [15:0] s);
    send_word(REQ_TABLE, pos, pair, c, s, 12'($urandom_range(0, 4095)), 16'($urandom));
    angle_loaded[pos*MAX_HALF_DIM + pair] = 1'b1;
  endtask

  // a pair at an in-table position is only completed where its angle entry is loaded
  task automatic send_element(input logic [11:0] pos, input logic signed [15:0] val);
    int unsigned e, dim, pair;
    bit          completes;
    dim       = 2 * gen_half;
    e         = (gen_count >= dim) ? 0 : gen_count;
    completes = gen_mode ? e[0] : (e >= gen_half);
    pair      = gen_mode ? (e >> 1) : (e - gen_half);
    if (completes && pos < MAX_POSITIONS && !angle_loaded[pos*MAX_HALF_DIM + pair])
      send_angle(pos[9:0], pair[5:0], random_angle(), random_angle());
    send_word(REQ_DATA, 10'($urandom), 6'($urandom), 16'($urandom), 16'($urandom),
              pos, val);
    gen_count = (completes && e + 1 == dim) ? 0 : e + 1;
  endtask

  // hold off the sender until every outstanding word has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
  endtask

  task automatic set_config(input bit wr_dim, input logic [7:0] dim,
                            input bit wr_mode, input logic mode);
    drain();
    // a half-filled head is held in the pair buffer, not in the pipeline
    repeat (SETTLE) @(posedge clk);
    if (wr_dim) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= REG_HEAD_DIM;
      cfg_wdata <= dim;
      @(posedge clk);
      gen_half  = half_span(dim);
      gen_count = 0;
    end
    if (wr_mode) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= REG_INTERLEAVED;
      cfg_wdata <= {7'($urandom_range(0, 127)), mode};
      @(posedge clk);
      gen_mode  = mode;
      gen_count = 0;
    end
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int   phase_len, r;
    bit   wr_dim, wr_mode;
    logic [7:0] dim;
    rst_n             <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_index         <= REG_HEAD_DIM;
    cfg_wdata         <= 8'd0;
    in_valid          <= 1'b0;
    in_req_type       <= REQ_DATA;
    in_table_position <= 10'd0;
    in_table_pair     <= 6'd0;
    in_table_cos      <= 16'sd0;
    in_table_sin      <= 16'sd0;
    in_position       <= 12'd0;
    in_value          <= 16'sd0;
    gen_half   = half_span(8'd128);
    gen_count  = 0;
    gen_mode   = 1'b0;
    burst_left = $urandom_range(1, 24);
    sent_words = 0;
    hot_positions[0] = 10'd0;
    hot_positions[1] = 10'd1023;
    for (int i = 2; i < 8; i++) hot_positions[i] = 10'($urandom_range(0, MAX_POSITIONS - 1));
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // split mode, four-element heads: positive saturation, rounding of halves,
    // out-of-table positions
    set_config(1'b1, 8'd4, 1'b1, 1'b0);
    send_angle(10'd0, 6'd0, 16'sd16384, 16'sd16384);
    send_angle(10'd0, 6'd1, -16'sd16384, 16'sd0);
    send_angle(10'd1023, 6'd0, 16'sd8192, -16'sd8192);
    send_element(12'd5, 16'sh7fff);
    send_element(12'd4095, 16'sh8000);
    send_element(12'd0, 16'sh8000);
    send_element(12'd4095, 16'sh7fff);
    send_element(12'd7, 16'sd1);
    send_element(12'd9, 16'sh8000);
    send_element(12'd1023, 16'sd0);
    send_element(12'd0, 16'sh8000);
    // odd head_dim gives one pair; adjacent pairing
    set_config(1'b1, 8'd3, 1'b1, 1'b1);
    send_element(12'd300, 16'sd100);
    send_element(12'd0, -16'sd100);
    send_element(12'd1, 16'sh8000);
    send_element(12'd2048, 16'sh7fff);

    while (sent_words < WORD_TARGET) begin
      r       = $urandom_range(0, 99);
      dim     = (r < 70) ? dim_choices[$urandom_range(0, 12)] : 8'($urandom_range(0, 255));
      wr_dim  = (r % 3 != 2);
      wr_mode = (r % 3 != 1);
      set_config(wr_dim, dim, wr_mode, 1'($urandom_range(0, 1)));
      phase_len = $urandom_range(16, 160);
      repeat (phase_len) begin
        r = $urandom_range(0, 99);
        if (r < 8)
          send_angle(10'($urandom_range(0, MAX_POSITIONS - 1)), 6'($urandom_range(0, 63)),
                     random_angle(), random_angle());
        else if (r < 10)
          drain();
        else
          send_element(choose_position(pair_completes()), random_value());
      end
    end

    drain();
    repeat (SETTLE * 4) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
